/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define AIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define AIC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/aic_pkg.sv */
// ----------------------------------------------------------------------------
// aic_pkg
// Types, constants and bit positions for the IP address classifier.
// ----------------------------------------------------------------------------
package aic_pkg;

  localparam int unsigned AddrHalfW = 64;
  localparam int unsigned AfW       = 9;
  localparam int unsigned MsW       = 6;
  localparam int unsigned PlW       = 8;
  localparam int unsigned NumChunks = 8;

  // address_flags bit positions
  localparam int unsigned AfWildcard = 0;
  localparam int unsigned AfBcast    = 1;
  localparam int unsigned AfAnyBcast = 2;
  localparam int unsigned AfLoopback = 3;
  localparam int unsigned AfMcast    = 4;
  localparam int unsigned AfLinkLoc  = 5;
  localparam int unsigned AfSiteLoc  = 6;
  localparam int unsigned AfV4Compat = 7;
  localparam int unsigned AfV4Mapped = 8;

  // mcast_scope_flags bit positions
  localparam int unsigned MsWellKnown = 0;
  localparam int unsigned MsNodeLoc   = 1;
  localparam int unsigned MsLinkLoc   = 2;
  localparam int unsigned MsSiteLoc   = 3;
  localparam int unsigned MsOrgLoc    = 4;
  localparam int unsigned MsGlobal    = 5;

  // IPv4 match values
  localparam logic [31:0] V4Mcast     = 32'hE000_0000;
  localparam logic [31:0] V4LinkLoc   = 32'hA9FE_0000;
  localparam logic [31:0] V4Priv192   = 32'hC0A8_0000;
  localparam logic [31:0] V4Priv172Lo = 32'hAC10_0000;
  localparam logic [31:0] V4Priv172Hi = 32'hAC1F_FFFF;
  localparam logic [31:0] V4Priv10    = 32'h0A00_0000;
  localparam logic [31:0] V4Loopback  = 32'h7F00_0000;
  localparam logic [31:0] V4GlobLo    = 32'hE000_0100;
  localparam logic [31:0] V4GlobHi    = 32'hEE00_0000;
  localparam logic [31:0] V4SiteScope = 32'hEFFF_0000;
  localparam logic [31:0] V4OrgScope  = 32'hEFC0_0000;

  // IPv6 top-word match values
  localparam logic [15:0] V6Mcast     = 16'hFF00;
  localparam logic [15:0] V6LinkLoc   = 16'hFE80;
  localparam logic [15:0] V6SiteLoc   = 16'hFEC0;
  localparam logic [15:0] V6LocalMask = 16'hFFE0;
  localparam logic [15:0] V6WkMask    = 16'hFFF0;
  localparam logic [15:0] V6ScopeMask = 16'hFFEF;
  localparam logic [15:0] V6ScNode    = 16'hFF01;
  localparam logic [15:0] V6ScLink    = 16'hFF02;
  localparam logic [15:0] V6ScSite    = 16'hFF05;
  localparam logic [15:0] V6ScOrg     = 16'hFF08;
  localparam logic [15:0] V6ScGlobal  = 16'hFF0F;

  // Stage 1 word: flags plus per-16-bit-chunk trailing-zero data
  typedef struct packed {
    logic                        is_v6;
    logic [AfW-1:0]              flags;
    logic [MsW-1:0]              scope;
    logic [NumChunks-1:0]        chunk_nz;
    logic [NumChunks-1:0][3:0]   chunk_tz;
  } s1_word_t;

  // Stage 2 word: trailing-zero count per 64-bit half
  typedef struct packed {
    logic           is_v6;
    logic [AfW-1:0] flags;
    logic [MsW-1:0] scope;
    logic           lo_nz;
    logic [5:0]     lo_tz;
    logic           hi_nz;
    logic [5:0]     hi_tz;
  } s2_word_t;

  // Result word
  typedef struct packed {
    logic [AfW-1:0] address_flags;
    logic [MsW-1:0] mcast_scope_flags;
    logic [PlW-1:0] prefix_len;
  } out_word_t;

endpackage

/* src/aic_in_if.sv */
// ----------------------------------------------------------------------------
// aic_in_if
// Address input channel: valid/ready plus address payload.
// ----------------------------------------------------------------------------
interface aic_in_if;
  import aic_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 is_v6;
  logic [AddrHalfW-1:0] addr_upper;
  logic [AddrHalfW-1:0] addr_lower;

  modport source (output valid, output is_v6, output addr_upper, output addr_lower,
                  input ready);
  modport sink   (input valid, input is_v6, input addr_upper, input addr_lower,
                  output ready);
endinterface

/* src/aic_out_if.sv */
// ----------------------------------------------------------------------------
// aic_out_if
// Classification result channel: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface aic_out_if;
  import aic_pkg::*;

  logic           valid;
  logic           ready;
  logic [AfW-1:0] address_flags;
  logic [MsW-1:0] mcast_scope_flags;
  logic [PlW-1:0] prefix_len;

  modport source (output valid, output address_flags, output mcast_scope_flags,
                  output prefix_len, input ready);
  modport sink   (input valid, input address_flags, input mcast_scope_flags,
                  input prefix_len, output ready);
endinterface

/* src/aic_match.sv */
// ----------------------------------------------------------------------------
// aic_match
// Stage 1: address class and scope compares, per-chunk trailing zeros.
// ----------------------------------------------------------------------------
module aic_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         is_v6_i,
  input  logic [aic_pkg::AddrHalfW-1:0] addr_upper_i,
  input  logic [aic_pkg::AddrHalfW-1:0] addr_lower_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output aic_pkg::s1_word_t            word_o
);
  import aic_pkg::*;

  // trailing zeros of a nonzero 16-bit chunk
  function automatic logic [3:0] tz16(input logic [15:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) n = 4'(i);
    end
    return n;
  endfunction

  logic [31:0]          a4;
  logic [15:0]          w0;
  logic [15:0]          sc;
  logic [AddrHalfW-1:0] lo_eff;
  logic [AddrHalfW-1:0] hi_eff;
  logic [AfW-1:0]       f4, f6;
  logic [MsW-1:0]       m4, m6;
  s1_word_t             word_d, word_q;
  logic                 valid_q;

  assign a4 = addr_lower_i[31:0];
  assign w0 = addr_upper_i[63:48];
  assign sc = w0 & V6ScopeMask;

  // IPv4 compares
  always_comb begin
    f4 = '0;
    m4 = '0;
    f4[AfWildcard] = (a4 == 32'h0);
    f4[AfBcast]    = (a4 == 32'hFFFF_FFFF);
    f4[AfAnyBcast] = (a4[7:0] == 8'hFF);
    f4[AfLoopback] = (a4[31:24] == V4Loopback[31:24]);
    f4[AfMcast]    = (a4[31:28] == V4Mcast[31:28]);
    f4[AfLinkLoc]  = (a4[31:16] == V4LinkLoc[31:16]);
    f4[AfSiteLoc]  = (a4[31:24] == V4Priv10[31:24]) || (a4[31:16] == V4Priv192[31:16]) ||
                     ((a4 >= V4Priv172Lo) && (a4 <= V4Priv172Hi));
    f4[AfV4Compat] = 1'b1;
    f4[AfV4Mapped] = 1'b1;
    m4[MsWellKnown] = (a4[31:8] == V4Mcast[31:8]);
    m4[MsLinkLoc]   = (a4[31:24] == V4Mcast[31:24]);
    m4[MsSiteLoc]   = (a4[31:16] == V4SiteScope[31:16]);
    m4[MsOrgLoc]    = (a4[31:16] == V4OrgScope[31:16]);
    m4[MsGlobal]    = (a4 >= V4GlobLo) && (a4 <= V4GlobHi);
  end

  // IPv6 compares
  always_comb begin
    f6 = '0;
    m6 = '0;
    f6[AfWildcard] = (addr_upper_i == '0) && (addr_lower_i == '0);
    f6[AfLoopback] = (addr_upper_i == '0) && (addr_lower_i == 64'd1);
    f6[AfMcast]    = ((w0 & V6LocalMask) == V6Mcast);
    f6[AfLinkLoc]  = ((w0 & V6LocalMask) == V6LinkLoc);
    f6[AfSiteLoc]  = ((w0 & V6LocalMask) == V6SiteLoc);
    f6[AfV4Compat] = (addr_upper_i == '0) && (addr_lower_i[63:32] == 32'h0);
    f6[AfV4Mapped] = (addr_upper_i == '0) && (addr_lower_i[63:32] == 32'h0000_FFFF);
    m6[MsWellKnown] = ((w0 & V6WkMask) == V6Mcast);
    m6[MsNodeLoc]   = (sc == V6ScNode);
    m6[MsLinkLoc]   = (sc == V6ScLink);
    m6[MsSiteLoc]   = (sc == V6ScSite);
    m6[MsOrgLoc]    = (sc == V6ScOrg);
    m6[MsGlobal]    = (sc == V6ScGlobal);
  end

  // IPv4 ignores everything above bit 31
  assign lo_eff = is_v6_i ? addr_lower_i : {32'h0, addr_lower_i[31:0]};
  assign hi_eff = is_v6_i ? addr_upper_i : '0;

  always_comb begin
    word_d.is_v6 = is_v6_i;
    word_d.flags = is_v6_i ? f6 : f4;
    word_d.scope = is_v6_i ? m6 : m4;
    for (int c = 0; c < NumChunks / 2; c++) begin
      word_d.chunk_nz[c]                 = |lo_eff[c*16 +: 16];
      word_d.chunk_tz[c]                 = tz16(lo_eff[c*16 +: 16]);
      word_d.chunk_nz[c + NumChunks / 2] = |hi_eff[c*16 +: 16];
      word_d.chunk_tz[c + NumChunks / 2] = tz16(hi_eff[c*16 +: 16]);
    end
  end

  // stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* src/aic_tzc.sv */
// ----------------------------------------------------------------------------
// aic_tzc
// Stage 2: folds chunk trailing-zero counts into one count per 64-bit half.
// ----------------------------------------------------------------------------
module aic_tzc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  aic_pkg::s1_word_t word_i,
  output logic              valid_o,
  input  logic              ready_i,
  output aic_pkg::s2_word_t word_o
);
  import aic_pkg::*;

  localparam int unsigned HalfChunks = NumChunks / 2;

  s2_word_t word_d, word_q;
  logic     valid_q;

  // lowest nonzero chunk wins; scan from the top down
  always_comb begin
    word_d.is_v6 = word_i.is_v6;
    word_d.flags = word_i.flags;
    word_d.scope = word_i.scope;
    word_d.lo_nz = |word_i.chunk_nz[HalfChunks-1:0];
    word_d.hi_nz = |word_i.chunk_nz[NumChunks-1:HalfChunks];
    word_d.lo_tz = '0;
    word_d.hi_tz = '0;
    for (int c = HalfChunks - 1; c >= 0; c--) begin
      if (word_i.chunk_nz[c]) begin
        word_d.lo_tz = {2'(c), word_i.chunk_tz[c]};
      end
      if (word_i.chunk_nz[c + HalfChunks]) begin
        word_d.hi_tz = {2'(c), word_i.chunk_tz[c + HalfChunks]};
      end
    end
  end

  // stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* src/aic_plen.sv */
// ----------------------------------------------------------------------------
// aic_plen
// Stage 3: prefix length from half counts; output register of the block.
// ----------------------------------------------------------------------------
module aic_plen (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  aic_pkg::s2_word_t  word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output aic_pkg::out_word_t word_o
);
  import aic_pkg::*;

  out_word_t      word_d, word_q;
  logic [PlW-1:0] lo_width;
  logic           valid_q;

  // IPv4 only spans the low 32 bits of the lower half
  assign lo_width = word_i.is_v6 ? PlW'(128) : PlW'(32);

  always_comb begin
    word_d.address_flags     = word_i.flags;
    word_d.mcast_scope_flags = word_i.scope;
    if (word_i.lo_nz) begin
      word_d.prefix_len = lo_width - {2'b00, word_i.lo_tz};
    end else if (word_i.hi_nz) begin
      word_d.prefix_len = PlW'(64) - {2'b00, word_i.hi_tz};
    end else begin
      word_d.prefix_len = '0;
    end
  end

  // output register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* src/ip_address_classifier_core.sv */
// ----------------------------------------------------------------------------
// ip_address_classifier_core
// Classifies one IPv4 or IPv6 address per word: class flags, multicast
// scope flags and prefix length.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one address word (is_v6, addr_upper, addr_lower); for IPv4
//         the address sits in addr_lower[31:0] and all other bits are ignored.
//   out_o carries one result word per address, in arrival order.
//   Both channels move a word on a clock edge with valid and ready high.
// Timing:
//   Three register stages: compares and 16-bit chunk zero counts, then the
//   per-half trailing-zero fold, then the prefix subtract into the output
//   register. Throughput is one word per cycle while out_o.ready stays high;
//   every stage takes a new word whenever it is empty or its contents move
//   on in the same cycle.
// Reset:
//   rst_ni clears all stage valid bits; the block takes words right after.
// Backpressure:
//   With out_o.ready low the words stay in place, the stages fill up in turn
//   and in_i.ready drops once all three hold a word. Nothing is dropped or
//   duplicated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ip_address_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  aic_in_if.sink      in_i,
  aic_out_if.source   out_o
);
  import aic_pkg::*;

  logic      s1_valid, s1_ready;
  logic      s2_valid, s2_ready;
  s1_word_t  s1_word;
  s2_word_t  s2_word;
  out_word_t res_word;

  // stage 1: compares
  aic_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .is_v6_i      (in_i.is_v6),
    .addr_upper_i (in_i.addr_upper),
    .addr_lower_i (in_i.addr_lower),
    .valid_o      (s1_valid),
    .ready_i      (s1_ready),
    .word_o       (s1_word)
  );

  // stage 2: trailing-zero fold
  aic_tzc u_tzc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .word_i  (s1_word),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .word_o  (s2_word)
  );

  // stage 3: prefix length and output register
  aic_plen u_plen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .word_i  (s2_word),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .word_o  (res_word)
  );

  assign out_o.address_flags     = res_word.address_flags;
  assign out_o.mcast_scope_flags = res_word.mcast_scope_flags;
  assign out_o.prefix_len        = res_word.prefix_len;

  // assertions
  `AIC_ASSERT(a_wildcard_zero_len, (out_o.valid && out_o.address_flags[AfWildcard]) |-> (out_o.prefix_len == '0), "wildcard address with nonzero prefix length")
  `AIC_ASSERT(a_v4_len_range, (out_o.valid && out_o.address_flags[AfV4Compat] && out_o.address_flags[AfV4Mapped]) |-> (out_o.prefix_len <= PlW'(32)), "IPv4 result with prefix length above 32")
  `AIC_ASSERT(a_latency, (in_i.valid && in_i.ready) ##1 out_o.ready ##1 out_o.ready |=> out_o.valid, "accepted word not delivered after three free cycles")
  `AIC_ASSERT_NEVER(a_wild_loop, out_o.valid && out_o.address_flags[AfWildcard] && out_o.address_flags[AfLoopback], "address flagged both wildcard and loopback")

endmodule
